// ===== rtl/bloom_filter_insert_query_top_assert.svh =====
// Assertion macros shared by the bloom filter checker.
`ifndef BLOOM_FILTER_INSERT_QUERY_TOP_ASSERT_SVH
`define BLOOM_FILTER_INSERT_QUERY_TOP_ASSERT_SVH

// Clocked assertion, off while reset is asserted.
`define BFIQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Signal holds while a transfer is stalled.
`define BFIQ_ASSERT_STALL(lbl, vld, rdy, sig, msg) \
  `BFIQ_ASSERT(lbl, (vld && !rdy) |=> $stable(sig), msg)

`endif

// ===== rtl/bfiq_pkg.sv =====
// Package: constants, types and state encoding of the bloom filter block.
`default_nettype none
package bfiq_pkg;

  localparam int FILTER_SIZE_BITS_DEF = 4096;
  localparam int MAX_PROBES_DEF       = 16;

  localparam int KEY_W        = 32;
  localparam int NUM_HASHES_W = 5;
  localparam int FBITS_W      = 13;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 16;

  localparam logic [NUM_HASHES_W-1:0] NUM_HASHES_RST = 5'd3;
  localparam logic [FBITS_W-1:0]      FBITS_RST      = 13'd4096;

  // exact hash ranges for at most four key bytes
  localparam int H1_W = 33;
  localparam int H2_W = 57;

  localparam int DJB2_INIT  = 5381;
  localparam int DJB2_SHIFT = 5;
  localparam int SDBM_SHL_A = 6;
  localparam int SDBM_SHL_B = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_HASHES  = 8'd0,
    REG_FILTER_BITS = 8'd1
  } cfg_reg_e;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HASH,
    ST_RED1,
    ST_RED2,
    ST_PROBE,
    ST_STEP1,
    ST_STEP2,
    ST_STEP3,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [H1_W-1:0] h1;
    logic [H2_W-1:0] h2;
  } hash_t;

endpackage
`default_nettype wire

// ===== rtl/bfiq_if.sv =====
// Handshake interfaces: key input, result output and register write channel.
`default_nettype none
interface bfiq_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [bfiq_pkg::KEY_W-1:0]   key;
  modport source (output valid, output kind, output key, input ready);
  modport sink   (input valid, input kind, input key, output ready);
endinterface

interface bfiq_out_if;
  logic valid;
  logic ready;
  logic present;
  modport source (output valid, output present, input ready);
  modport sink   (input valid, input present, output ready);
endinterface

interface bfiq_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bfiq_pkg::CFG_IDX_W-1:0]   index;
  logic [bfiq_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/bfiq_hash.sv =====
// Byte-serial djb2 and sdbm hash of the key bytes up to the first zero byte.
`default_nettype none
module bfiq_hash (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [bfiq_pkg::KEY_W-1:0] key_i,
  output logic                            done_o,
  output bfiq_pkg::hash_t                 hash_o
);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [1:0]                 cnt_q, cnt_d;
  logic [bfiq_pkg::KEY_W-1:0] key_q, key_d;
  bfiq_pkg::hash_t            h_q, h_d;
  logic [7:0]                 byte_c;

  assign byte_c = key_q[7:0];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    key_d  = key_q;
    h_d    = h_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 2'd0;
      key_d  = key_i;
      h_d.h1 = bfiq_pkg::H1_W'(bfiq_pkg::DJB2_INIT);
      h_d.h2 = '0;
    end else if (busy_q) begin
      if (byte_c == 8'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        h_d.h1 = (h_q.h1 << bfiq_pkg::DJB2_SHIFT) + h_q.h1
                 + bfiq_pkg::H1_W'(byte_c);
        h_d.h2 = bfiq_pkg::H2_W'(byte_c) + (h_q.h2 << bfiq_pkg::SDBM_SHL_A)
                 + (h_q.h2 << bfiq_pkg::SDBM_SHL_B) - h_q.h2;
        key_d  = key_q >> 8;
        cnt_d  = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    h_q   <= h_d;
  end

  assign done_o = done_q;
  assign hash_o = h_q;

endmodule
`default_nettype wire

// ===== rtl/bfiq_modadd.sv =====
// Modular adder: (a + b + cin) mod m for a, b below m, one compare and subtract.
`default_nettype none
module bfiq_modadd #(
  parameter int IW = 12,
  parameter int MW = 13
) (
  input  wire logic [IW-1:0] a_i,
  input  wire logic [IW-1:0] b_i,
  input  wire logic          cin_i,
  input  wire logic [MW-1:0] mod_i,
  output logic      [IW-1:0] res_o
);

  logic [IW:0] sum;
  logic [IW:0] m_ext;

  assign sum   = {1'b0, a_i} + {1'b0, b_i} + (IW+1)'(cin_i);
  assign m_ext = (IW+1)'(mod_i);

  always_comb begin
    if (sum >= m_ext) begin
      res_o = IW'(sum - m_ext);
    end else begin
      res_o = IW'(sum);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bfiq_bitmem.sv =====
// Single-port filter bit memory with a clearing sweep after reset.
`default_nettype none
module bfiq_bitmem #(
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  output logic                          rdata_o,
  output logic                          clr_busy_o
);

  localparam int AW = $clog2(DEPTH);

  logic          mem [DEPTH];
  logic          rdata_q;
  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_q, clr_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_d      = clr_q;
    if (clr_busy_q) begin
      clr_d = clr_q + AW'(1);
      if (clr_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_q      <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_q      <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_q] <= 1'b0;
    end else if (en_i && we_i) begin
      mem[addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign clr_busy_o = clr_busy_q;

endmodule
`default_nettype wire

// ===== rtl/bloom_filter_insert_query_top.sv =====
// Bloom filter top level: sequencer, configuration registers and result register.
// Each key is hashed (djb2 and sdbm over its bytes up to the first zero byte),
// both hashes are reduced mod the active filter size bit by bit, and then the
// probes (h1 + i*h2 + i*i) mod m are walked; insert sets the bits, query
// reports present only if all probed bits are set. One item is worked on at a
// time, k probes per item (num_hashes capped at MAX_PROBES): byte hashing of
// up to four key bytes, bit-serial reduction of the 33-bit h1 and then the 57-bit
// h2, and the PROBE and STEP states for each probe, all paced by the
// single modular adder and the single-port bit memory. After reset the bit
// memory is swept clear, during which no key is taken; register writes are
// taken at any time. filter_bits_in_use of 0 acts as 1 and values above
// FILTER_SIZE_BITS act as FILTER_SIZE_BITS.
`default_nettype none
module bloom_filter_insert_query_top #(
  parameter int FILTER_SIZE_BITS = bfiq_pkg::FILTER_SIZE_BITS_DEF,
  parameter int MAX_PROBES       = bfiq_pkg::MAX_PROBES_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bfiq_in_if.sink     in_i,
  bfiq_out_if.source  out_o,
  bfiq_cfg_if.sink    cfg_i
);

  localparam int IW  = $clog2(FILTER_SIZE_BITS);
  localparam int MW  = $clog2(FILTER_SIZE_BITS + 1);
  localparam int CW  = (MW > bfiq_pkg::FBITS_W) ? MW : bfiq_pkg::FBITS_W;
  localparam int PW  = $clog2(MAX_PROBES + 1);
  localparam int KW  = (PW > bfiq_pkg::NUM_HASHES_W) ? PW : bfiq_pkg::NUM_HASHES_W;
  localparam int BCW = $clog2(bfiq_pkg::H2_W);

  bfiq_pkg::state_e                state_q, state_d;
  bfiq_pkg::kind_e                 kind_q, kind_d;
  logic [bfiq_pkg::H2_W-1:0]       sh_q, sh_d;
  logic [BCW-1:0]                  bc_q, bc_d;
  logic [IW-1:0]                   v_q, v_d;
  logic [IW-1:0]                   h2r_q, h2r_d;
  logic [IW-1:0]                   ir_q, ir_d;
  logic [PW-1:0]                   pc_q, pc_d;
  logic                            allset_q, allset_d;
  logic                            out_valid_q, out_valid_d;
  logic                            present_q, present_d;
  logic [bfiq_pkg::NUM_HASHES_W-1:0] nh_q;
  logic [bfiq_pkg::FBITS_W-1:0]      fb_q;

  logic                            in_xfer;
  logic                            hash_done;
  bfiq_pkg::hash_t                 hash;
  logic [IW-1:0]                   ua, ub, ures;
  logic                            uc;
  logic                            mem_en, mem_rdata, clr_busy;
  logic [CW-1:0]                   fb_ext, m_wide;
  logic [MW-1:0]                   m_eff;
  logic [KW-1:0]                   nh_ext, k_wide;
  logic [PW-1:0]                   k_eff;

  // effective modulus and probe count
  always_comb begin
    fb_ext = CW'(fb_q);
    if (fb_ext == '0) begin
      m_wide = CW'(1);
    end else if (fb_ext > CW'(FILTER_SIZE_BITS)) begin
      m_wide = CW'(FILTER_SIZE_BITS);
    end else begin
      m_wide = fb_ext;
    end
    m_eff  = MW'(m_wide);
    nh_ext = KW'(nh_q);
    if (nh_ext > KW'(MAX_PROBES)) begin
      k_wide = KW'(MAX_PROBES);
    end else begin
      k_wide = nh_ext;
    end
    k_eff = PW'(k_wide);
  end

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nh_q <= bfiq_pkg::NUM_HASHES_RST;
      fb_q <= bfiq_pkg::FBITS_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == bfiq_pkg::REG_NUM_HASHES) begin
        nh_q <= cfg_i.data[bfiq_pkg::NUM_HASHES_W-1:0];
      end else if (cfg_i.index == bfiq_pkg::REG_FILTER_BITS) begin
        fb_q <= cfg_i.data[bfiq_pkg::FBITS_W-1:0];
      end
    end
  end

  assign in_i.ready = (state_q == bfiq_pkg::ST_IDLE) && !clr_busy;
  assign in_xfer    = in_i.valid && in_i.ready;

  bfiq_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .key_i   (in_i.key),
    .done_o  (hash_done),
    .hash_o  (hash)
  );

  bfiq_modadd #(
    .IW (IW),
    .MW (MW)
  ) u_modadd (
    .a_i   (ua),
    .b_i   (ub),
    .cin_i (uc),
    .mod_i (m_eff),
    .res_o (ures)
  );

  assign mem_en = (state_q == bfiq_pkg::ST_PROBE);

  bfiq_bitmem #(
    .DEPTH (FILTER_SIZE_BITS)
  ) u_bitmem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (mem_en),
    .we_i       (kind_q == bfiq_pkg::KIND_INSERT),
    .addr_i     (v_q),
    .rdata_o    (mem_rdata),
    .clr_busy_o (clr_busy)
  );

  // shared adder operand select
  always_comb begin
    ua = '0;
    ub = '0;
    uc = 1'b0;
    unique case (state_q)
      bfiq_pkg::ST_RED1: begin
        ua = v_q;
        ub = v_q;
        uc = sh_q[bfiq_pkg::H2_W-1];
      end
      bfiq_pkg::ST_RED2: begin
        ua = h2r_q;
        ub = h2r_q;
        uc = sh_q[bfiq_pkg::H2_W-1];
      end
      bfiq_pkg::ST_PROBE: begin
        ua = v_q;
        ub = h2r_q;
        uc = 1'b1;
      end
      bfiq_pkg::ST_STEP1, bfiq_pkg::ST_STEP2: begin
        ua = v_q;
        ub = ir_q;
      end
      bfiq_pkg::ST_STEP3: begin
        ua = ir_q;
        uc = 1'b1;
      end
      default: begin
        ua = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    sh_d        = sh_q;
    bc_d        = bc_q;
    v_d         = v_q;
    h2r_d       = h2r_q;
    ir_d        = ir_q;
    pc_d        = pc_q;
    allset_d    = allset_q;
    present_d   = present_q;
    out_valid_d = out_valid_q && !out_o.ready;
    unique case (state_q)
      bfiq_pkg::ST_IDLE: begin
        if (in_xfer) begin
          kind_d  = bfiq_pkg::kind_e'(in_i.kind);
          state_d = bfiq_pkg::ST_HASH;
        end
      end
      bfiq_pkg::ST_HASH: begin
        if (hash_done) begin
          sh_d    = {hash.h1, {(bfiq_pkg::H2_W - bfiq_pkg::H1_W){1'b0}}};
          bc_d    = '0;
          v_d     = '0;
          state_d = bfiq_pkg::ST_RED1;
        end
      end
      bfiq_pkg::ST_RED1: begin
        v_d  = ures;
        sh_d = sh_q << 1;
        bc_d = bc_q + BCW'(1);
        if (bc_q == BCW'(bfiq_pkg::H1_W - 1)) begin
          sh_d    = hash.h2;
          bc_d    = '0;
          h2r_d   = '0;
          state_d = bfiq_pkg::ST_RED2;
        end
      end
      bfiq_pkg::ST_RED2: begin
        h2r_d = ures;
        sh_d  = sh_q << 1;
        bc_d  = bc_q + BCW'(1);
        if (bc_q == BCW'(bfiq_pkg::H2_W - 1)) begin
          ir_d     = '0;
          pc_d     = '0;
          allset_d = 1'b1;
          if (k_eff == '0) begin
            state_d = bfiq_pkg::ST_FINISH;
          end else begin
            state_d = bfiq_pkg::ST_PROBE;
          end
        end
      end
      bfiq_pkg::ST_PROBE: begin
        v_d     = ures;
        state_d = bfiq_pkg::ST_STEP1;
      end
      bfiq_pkg::ST_STEP1: begin
        if (!mem_rdata) begin
          allset_d = 1'b0;
        end
        v_d     = ures;
        state_d = bfiq_pkg::ST_STEP2;
      end
      bfiq_pkg::ST_STEP2: begin
        v_d     = ures;
        state_d = bfiq_pkg::ST_STEP3;
      end
      bfiq_pkg::ST_STEP3: begin
        ir_d = ures;
        pc_d = pc_q + PW'(1);
        if ((pc_q + PW'(1)) == k_eff) begin
          state_d = bfiq_pkg::ST_FINISH;
        end else begin
          state_d = bfiq_pkg::ST_PROBE;
        end
      end
      bfiq_pkg::ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          present_d   = (kind_q == bfiq_pkg::KIND_QUERY) && allset_q;
          state_d     = bfiq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bfiq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfiq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    sh_q      <= sh_d;
    bc_q      <= bc_d;
    v_q       <= v_d;
    h2r_q     <= h2r_d;
    ir_q      <= ir_d;
    pc_q      <= pc_d;
    allset_q  <= allset_d;
    present_q <= present_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.present = present_q;

endmodule
`default_nettype wire

// ===== rtl/bfiq_checker.sv =====
// Port-level checker for the bloom filter top level, with its bind.
`default_nettype none
`include "bloom_filter_insert_query_top_assert.svh"
module bfiq_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_present_i
);

  logic       in_xfer, out_xfer;
  logic [1:0] pend_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_q + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  `BFIQ_ASSERT(a_out_hold, (out_valid_i && !out_ready_i) |=> out_valid_i, "result dropped")
  `BFIQ_ASSERT_STALL(a_out_stable, out_valid_i, out_ready_i, out_present_i, "result changed")
  `BFIQ_ASSERT(a_busy_after_xfer, in_xfer |=> !in_ready_i, "ready after key transfer")
  `BFIQ_ASSERT(a_no_spurious, out_valid_i |-> (pend_q != 2'd0), "result without key")
  `BFIQ_ASSERT(a_depth, (pend_q == 2'd2) |-> !in_ready_i, "too many keys in flight")

endmodule

bind bloom_filter_insert_query_top bfiq_checker u_bfiq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_present_i (out_o.present)
);
`default_nettype wire
